FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SHM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define SHM_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SHM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHM_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/shm_pkg.sv
`timescale 1ns / 1ps

package shm_pkg;

  // field widths
  localparam int MOD_BITS     = 61;
  localparam int WORD_BYTES   = 8;
  localparam int WORD_BITS    = 8 * WORD_BYTES;
  localparam int TAG_BITS     = 61;
  localparam int CFG_BITS     = 61;
  localparam int CFG_IDX_BITS = 1;

  // key plus message word, one bit of carry
  localparam int SUM_BITS  = ((WORD_BITS > MOD_BITS) ? WORD_BITS : MOD_BITS) + 1;
  localparam int RED_STEPS = SUM_BITS;
  localparam int MUL_STEPS = MOD_BITS;
  localparam int CNT_BITS  = $clog2(RED_STEPS);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_A = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRIME = 1'd1;

  // reset modulus 2^61-1
  localparam logic [MOD_BITS-1:0] PRIME_RESET = MOD_BITS'(64'h1FFF_FFFF_FFFF_FFFF);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_load;
    logic mul_step;
    logic fin;
    logic out_load;
  } shm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic p_small;
    logic last;
    logic out_busy;
  } shm_stat_t;

endpackage

FILE: rtl/shm_in_if.sv
`timescale 1ns / 1ps

// message word channel
interface shm_in_if
  import shm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] message_word;
  logic                 last_word;

  modport source (output valid, output message_word, output last_word, input ready);
  modport sink (input valid, input message_word, input last_word, output ready);
endinterface

FILE: rtl/shm_out_if.sv
`timescale 1ns / 1ps

// tag channel
interface shm_out_if
  import shm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TAG_BITS-1:0] tag;

  modport source (output valid, output tag, input ready);
  modport sink (input valid, input tag, output ready);
endinterface

FILE: rtl/shm_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shm_ctrl
  import shm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  shm_stat_t stat,
  output shm_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_LDM  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = stat.p_small ? ST_FIN : ST_RED;
        end
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(RED_STEPS - 1)) begin
          state_nxt = ST_LDM;
        end
      end
      ST_LDM: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(MUL_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // a last word holds while an earlier tag still waits in the output slot
        if (!(stat.last && stat.out_busy)) begin
          cmd.fin      = 1'b1;
          cmd.out_load = stat.last;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `SHM_ASSERT(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (state_r == ST_RED || state_r == ST_FIN), "item accepted but no work started")
  `SHM_NEVER(a_red_cnt_range, clk, rst_n, (state_r == ST_RED) && (cnt_r > CNT_BITS'(RED_STEPS - 1)), "reduction counter overrun")
  `SHM_ASSERT(a_mul_entry, clk, rst_n, (state_r == ST_MUL && $past(state_r) != ST_MUL) |-> $past(state_r) == ST_LDM, "multiply entered without operand load")

endmodule

FILE: rtl/shm_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shm_dpath
  import shm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic [WORD_BITS-1:0]    in_message_word,
  input  logic                    in_last_word,
  input  shm_cmd_t                cmd,
  output shm_stat_t               stat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TAG_BITS-1:0]     out_tag
);

  logic [MOD_BITS-1:0] key_r, prime_r, sum_r;
  logic [SUM_BITS-1:0] val_sh_r, sum_sh_r;
  logic [MOD_BITS-1:0] red_r, sred_r;
  logic [MOD_BITS-1:0] t_r, t_sh_r, mr_r;
  logic                last_r;
  logic                out_valid_r;
  logic [TAG_BITS-1:0] out_tag_r;

  logic [MOD_BITS:0]   red_try, sred_try, fin_try, p1_w;
  logic [MOD_BITS-1:0] red_nxt, sred_nxt, fin_nxt, mr_nxt;
  logic [MOD_BITS+1:0] mul_try, mul_p1, mul_p2;
  logic                p_small;

  assign p_small = (prime_r[MOD_BITS-1:1] == '0);
  assign p1_w    = {1'b0, prime_r};

  // one shift-subtract step of key+word mod p
  assign red_try = {red_r, val_sh_r[SUM_BITS-1]};
  assign red_nxt = (red_try >= p1_w) ? MOD_BITS'(red_try - p1_w) : MOD_BITS'(red_try);

  // same step for the stored residue, in its own lane
  assign sred_try = {sred_r, sum_sh_r[SUM_BITS-1]};
  assign sred_nxt = (sred_try >= p1_w) ? MOD_BITS'(sred_try - p1_w) : MOD_BITS'(sred_try);

  // double-and-add square step, sum below 3p, result below p
  assign mul_p1  = {2'b00, prime_r};
  assign mul_p2  = {1'b0, prime_r, 1'b0};
  assign mul_try = {1'b0, mr_r, 1'b0} + (t_sh_r[MOD_BITS-1] ? {2'b00, t_r} : '0);
  always_comb begin
    if (mul_try >= mul_p2) begin
      mr_nxt = MOD_BITS'(mul_try - mul_p2);
    end else if (mul_try >= mul_p1) begin
      mr_nxt = MOD_BITS'(mul_try - mul_p1);
    end else begin
      mr_nxt = MOD_BITS'(mul_try);
    end
  end

  // residue plus square, one modular add
  assign fin_try = {1'b0, sred_r} + {1'b0, mr_r};
  assign fin_nxt = (fin_try >= p1_w) ? MOD_BITS'(fin_try - p1_w) : MOD_BITS'(fin_try);

  // configuration and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      prime_r <= PRIME_RESET;
      sum_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_KEY_A) begin
        key_r <= MOD_BITS'(cfg_data);
      end
      if (cfg_we && cfg_index == REG_PRIME) begin
        prime_r <= MOD_BITS'(cfg_data);
      end
      if (cmd.fin) begin
        sum_r <= p_small ? '0 : fin_nxt;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_sh_r <= SUM_BITS'(key_r) + SUM_BITS'(in_message_word);
      sum_sh_r <= SUM_BITS'(sum_r);
      red_r    <= '0;
      sred_r   <= '0;
      last_r   <= in_last_word;
    end else if (cmd.red_step) begin
      val_sh_r <= {val_sh_r[SUM_BITS-2:0], 1'b0};
      sum_sh_r <= {sum_sh_r[SUM_BITS-2:0], 1'b0};
      red_r    <= red_nxt;
      sred_r   <= sred_nxt;
    end
    if (cmd.mul_load) begin
      t_r    <= red_r;
      t_sh_r <= red_r;
      mr_r   <= '0;
    end else if (cmd.mul_step) begin
      t_sh_r <= {t_sh_r[MOD_BITS-2:0], 1'b0};
      mr_r   <= mr_nxt;
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tag_r <= p_small ? '0 : TAG_BITS'(fin_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tag       = out_tag_r;
  assign stat.p_small  = p_small;
  assign stat.last     = last_r;
  assign stat.out_busy = out_valid_r && !out_ready;

  `SHM_ASSERT(a_red_bound, clk, rst_n, ($past(cmd.red_step) && !p_small) |-> (red_r < prime_r), "key plus word remainder not below modulus")
  `SHM_ASSERT(a_mul_bound, clk, rst_n, ($past(cmd.mul_step) && !p_small) |-> (mr_r < prime_r), "square partial not below modulus")
  `SHM_ASSERT(a_sum_bound, clk, rst_n, $past(cmd.fin) |-> (sum_r < prime_r || sum_r == '0), "accumulator left unreduced")

endmodule

FILE: rtl/square_hash_mac_accumulator.sv
// Square-hash MAC: every message word m adds (key_a + m)^2 to a residue kept mod
// prime_modulus; a word marked last_word delivers that residue as tag, and the residue
// carries on until reset. An item is loaded, then goes through one shift-subtract
// reduction of key+word and of the stored residue (two lanes side by side), an
// operand set-up, one double-and-add squaring step per modulus bit, and the final
// modular add. With a modulus below two the item skips reduction and squaring and
// the residue is 0. A tag waits in an output register; the next word is taken
// meanwhile, and only a further last word stalls at its final step until the
// waiting tag is taken.
`timescale 1ns / 1ps

module square_hash_mac_accumulator
  import shm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  shm_in_if.sink                  in_ch,
  shm_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  shm_cmd_t  cmd;
  shm_stat_t stat;

  // sequencer
  shm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and registers
  shm_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_message_word (in_ch.message_word),
    .in_last_word    (in_ch.last_word),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_tag         (out_ch.tag)
  );

endmodule

FILE: verif/tb_square_hash_mac_accumulator.sv
`timescale 1ns / 1ps

module tb_square_hash_mac_accumulator;
  import shm_pkg::*;

  // drain wait, longer than one item of the block takes
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int RANDOM_WORDS = 1200;
  localparam logic [CFG_BITS-1:0] ALL_ONES_61 = CFG_BITS'(64'h1FFF_FFFF_FFFF_FFFF);

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [CFG_BITS-1:0]     reg_val;
    logic [WORD_BITS-1:0]    word;
    logic                    last;
    logic                    known;
    logic [TAG_BITS-1:0]     tag;
  } stim_row_t;

  // directed rows: register writes and words, a tag typed in where it is obvious
  localparam int N_DIRECTED = 30;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // reset key and modulus: zero word gives zero, then one gives one
    '{ROW_WORD, REG_KEY_A, '0, 64'h0, 1'b1, 1'b1, 61'd0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h1, 1'b1, 1'b1, 61'd1},
    // word extremes
    '{ROW_WORD, REG_KEY_A, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h8000_0000_0000_0000, 1'b1, 1'b0, '0},
    // key equal to the modulus, reduced to zero
    '{ROW_REG, REG_KEY_A, ALL_ONES_61, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h0, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h1FFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, '0},
    // modulus zero and one clear everything
    '{ROW_REG, REG_PRIME, 61'd0, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'hDEAD_BEEF_0123_4567, 1'b1, 1'b1, 61'd0},
    '{ROW_REG, REG_PRIME, 61'd1, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 61'd0},
    // smallest modulus, key above it
    '{ROW_REG, REG_PRIME, 61'd2, '0, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_KEY_A, 61'd3, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h1, 1'b1, 1'b0, '0},
    // modulus changed in the middle of a message
    '{ROW_REG, REG_PRIME, ALL_ONES_61, '0, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_KEY_A, 61'h0123_4567_89AB_CDEF, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_PRIME, 61'd1000003, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0},
    // composite modulus with the widest key
    '{ROW_REG, REG_PRIME, 61'd15, '0, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_KEY_A, ALL_ONES_61, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h7, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 1'b0, '0},
    // back to reset values, tags back to back
    '{ROW_REG, REG_PRIME, ALL_ONES_61, '0, 1'b0, 1'b0, '0},
    '{ROW_REG, REG_KEY_A, 61'd0, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h1, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h2, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'h3, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_KEY_A, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  shm_in_if  in_ch ();
  shm_out_if out_ch ();

  square_hash_mac_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block's registers and running residue
  logic [CFG_BITS-1:0] cur_key;
  logic [MOD_BITS-1:0] cur_modulus;
  logic [TAG_BITS-1:0] residue;

  logic [TAG_BITS-1:0] pending_tags [$];
  int errors;
  int cycles;
  int burst_left;
  int words_sent;

  always #1 clk = ~clk;

  // residue after folding in (key + word)^2, all mod the current modulus
  function automatic logic [TAG_BITS-1:0] fold_word(input logic [TAG_BITS-1:0] acc,
                                                   input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS:0]    t;
    logic [2*MOD_BITS-1:0] prod;
    logic [MOD_BITS:0]     s;
    if (cur_modulus < 2) return '0;
    t = (WORD_BITS+1)'(cur_key % cur_modulus) + (WORD_BITS+1)'(m % cur_modulus);
    if (t >= cur_modulus) t = t - cur_modulus;
    prod = t[MOD_BITS-1:0] * t[MOD_BITS-1:0];
    prod = prod % cur_modulus;
    s = (MOD_BITS+1)'(acc % cur_modulus) + (MOD_BITS+1)'(prod);
    if (s >= cur_modulus) s = s - cur_modulus;
    return s[TAG_BITS-1:0];
  endfunction

  // offer one item in bursts with random gaps, predict on acceptance
  task automatic send_word(input logic [WORD_BITS-1:0] m, input logic last,
                           input logic known, input logic [TAG_BITS-1:0] typed_tag);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 140)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= m;
    in_ch.last_word    <= last;
    do @(posedge clk); while (!in_ch.ready);
    residue = fold_word(residue, m);
    if (last) pending_tags.push_back(known ? typed_tag : residue);
    burst_left--;
    words_sent++;
  endtask

  // drop valid, wait for every tag, then for any word still in the pipe
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write cycle, then a quiet cycle so writes never share a time step
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY_A) cur_key = val;
    else cur_modulus = val[MOD_BITS-1:0];
    @(posedge clk);
  endtask

  // tag checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tags.size() == 0) begin
        $error("tag: expected none, actual %h", out_ch.tag);
        errors++;
      end else begin
        if (out_ch.tag !== pending_tags[0]) begin
          $error("tag: expected %h, actual %h", pending_tags[0], out_ch.tag);
          errors++;
        end
        void'(pending_tags.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: stall pattern drawn anew at random from four modes
  initial begin
    int cnt;
    int mode;
    cnt  = 0;
    mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cnt++;
      if (cnt % 256 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= (cnt % 5 == 0);
        2: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (cnt % 20 >= 16);
      endcase
    end
  end

  // stimulus
  initial begin
    int n_msg;
    int len;
    logic cut;
    logic [WORD_BITS-1:0] w;
    logic [CFG_BITS-1:0]  p;
    logic [CFG_BITS-1:0]  k;
    errors     = 0;
    cycles     = 0;
    burst_left = 0;
    words_sent = 0;
    cur_key     = '0;
    cur_modulus = PRIME_RESET;
    residue     = '0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_KEY_A;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.message_word <= '0;
    in_ch.last_word    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        settle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        send_word(DIRECTED[i].word, DIRECTED[i].last, DIRECTED[i].known, DIRECTED[i].tag);
      end
    end

    // random part: one register setting per phase, a few messages each
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      settle();
      case ($urandom_range(0, 9))
        0, 7: p = ALL_ONES_61;
        1: p = 61'd2;
        2: p = 61'd3;
        3: p = CFG_BITS'({$urandom, $urandom}) | (61'd1 << (CFG_BITS - 1));
        4: p = CFG_BITS'($urandom_range(2, 1000));
        5: p = CFG_BITS'({$urandom, $urandom});
        6: p = CFG_BITS'($urandom_range(0, 1));
        8: p = 61'd4294967291;
        default: p = CFG_BITS'({$urandom, $urandom}) | 61'd1;
      endcase
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = ALL_ONES_61;
        2: k = CFG_BITS'($urandom_range(0, 255));
        default: k = CFG_BITS'({$urandom, $urandom});
      endcase
      if ($urandom_range(0, 4) != 0) write_reg(REG_PRIME, p);
      if ($urandom_range(0, 4) != 0) write_reg(REG_KEY_A, k);
      n_msg = $urandom_range(1, 8);
      for (int j = 0; j < n_msg; j++) begin
        len = $urandom_range(1, 5);
        // now and then leave the message open across the next register write
        cut = (j == n_msg - 1) && ($urandom_range(0, 7) == 0);
        for (int b = 0; b < len; b++) begin
          case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2: w = WORD_BITS'($urandom_range(0, 65535));
            default: w = {$urandom, $urandom};
          endcase
          send_word(w, (b == len - 1) && !cut, 1'b0, '0);
        end
      end
    end

    // wind down
    in_ch.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
